// ----- design/ps2md_pkg.sv -----
`default_nettype none

package ps2md_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned GAP_W = 16;
   localparam int unsigned BTN_W = 3;

   localparam logic [GAP_W-1:0] GAP_TIMEOUT_RESET = 16'd20;

   localparam logic [BYTE_W-1:0] CONNECT_HEADER = 8'hAA;
   localparam logic [BYTE_W-1:0] CONNECT_ID = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_MID = 8'h80;
   localparam logic [BYTE_W-1:0] SAT_POS = 8'h7F;
   localparam logic [BYTE_W-1:0] SAT_NEG = 8'h80;
   localparam logic [BTN_W-1:0] BTN_INVERT = 3'b111;

   localparam int unsigned HDR_LEFT_BIT = 0;
   localparam int unsigned HDR_MID_BIT = 2;
   localparam int unsigned HDR_RIGHT_BIT = 1;
   localparam int unsigned HDR_SIGN_X_BIT = 4;
   localparam int unsigned HDR_SIGN_Y_BIT = 5;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] data_byte;
      logic [TIME_W-1:0] arrival_time;
   } req_type;

   typedef struct packed {
      logic              packet_ready;
      logic              connect_seen;
      logic [BTN_W-1:0]  buttons;
      logic [BYTE_W-1:0] delta_x;
      logic [BYTE_W-1:0] delta_y;
      logic [BYTE_W-1:0] raw_first;
      logic [BYTE_W-1:0] raw_second;
      logic [BYTE_W-1:0] raw_third;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/ps2md_if.sv -----
`default_nettype none

interface ps2md_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [ps2md_pkg::BYTE_W-1:0]    data_byte;
   logic [ps2md_pkg::TIME_W-1:0]    arrival_time;

   modport source (output valid, output cmd, output data_byte, output arrival_time,
                   input ready);
   modport sink (input valid, input cmd, input data_byte, input arrival_time,
                 output ready);
endinterface

interface ps2md_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  packet_ready;
   logic                                  connect_seen;
   logic [ps2md_pkg::BTN_W-1:0]           buttons;
   logic signed [ps2md_pkg::BYTE_W-1:0]   delta_x;
   logic signed [ps2md_pkg::BYTE_W-1:0]   delta_y;
   logic [ps2md_pkg::BYTE_W-1:0]          raw_first;
   logic [ps2md_pkg::BYTE_W-1:0]          raw_second;
   logic [ps2md_pkg::BYTE_W-1:0]          raw_third;

   modport source (output valid, output packet_ready, output connect_seen,
                   output buttons, output delta_x, output delta_y,
                   output raw_first, output raw_second, output raw_third,
                   input ready);
   modport sink (input valid, input packet_ready, input connect_seen,
                 input buttons, input delta_x, input delta_y,
                 input raw_first, input raw_second, input raw_third,
                 output ready);
endinterface

`default_nettype wire

// ----- design/ps2md_in_reg.sv -----
`default_nettype none

module ps2md_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire ps2md_pkg::req_type in_item,
   input  wire logic               advance,
   output      logic               item_valid,
   output      ps2md_pkg::req_type item
);

   logic               valid_ff;
   logic               valid_in;
   ps2md_pkg::req_type item_ff;
   logic               accept;

   assign in_ready = !reset && (!valid_ff || advance);
   assign accept = in_valid && in_ready;
   assign valid_in = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload until the next item is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

// ----- design/ps2md_decode.sv -----
`default_nettype none

module ps2md_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire ps2md_pkg::req_type            item,
   input  wire logic [ps2md_pkg::GAP_W-1:0]   gap_timeout,
   output      ps2md_pkg::rsp_type            result
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_XBYTE,
      PH_YBYTE,
      PH_HOLD
   } phase_type;

   phase_type                        phase_ff, phase_in, phase_eff;
   logic [ps2md_pkg::TIME_W-1:0]     last_time_ff, last_time_in;
   logic [ps2md_pkg::BYTE_W-1:0]     held_header_ff, held_header_in;
   logic [ps2md_pkg::BYTE_W-1:0]     held_xbyte_ff, held_xbyte_in;
   logic [ps2md_pkg::BTN_W-1:0]      held_buttons_ff, held_buttons_in;
   logic [ps2md_pkg::BYTE_W-1:0]     held_dx_ff, held_dx_in;
   logic                             sign_x_ff, sign_x_in;
   logic                             sign_y_ff, sign_y_in;
   logic [ps2md_pkg::TIME_W-1:0]     elapsed;
   logic                             timed_out;
   logic [ps2md_pkg::BYTE_W-1:0]     c;
   logic [ps2md_pkg::BYTE_W-1:0]     neg_c;
   logic [ps2md_pkg::BYTE_W-1:0]     dy;

   assign c = item.data_byte;
   assign neg_c = ps2md_pkg::BYTE_W'(0) - c;
   assign elapsed = item.arrival_time - last_time_ff;
   assign timed_out = elapsed > {{(ps2md_pkg::TIME_W - ps2md_pkg::GAP_W){1'b0}}, gap_timeout};

   always_comb begin
      phase_in = phase_ff;
      last_time_in = last_time_ff;
      held_header_in = held_header_ff;
      held_xbyte_in = held_xbyte_ff;
      held_buttons_in = held_buttons_ff;
      held_dx_in = held_dx_ff;
      sign_x_in = sign_x_ff;
      sign_y_in = sign_y_ff;
      result = '0;
      dy = '0;
      phase_eff = phase_ff;

      if (item.cmd) begin
         phase_in = PH_HEADER;
      end else begin
         last_time_in = item.arrival_time;
         // drop a partial packet after a long gap
         if (timed_out && (phase_ff == PH_XBYTE || phase_ff == PH_YBYTE)) begin
            phase_eff = PH_HEADER;
         end
         unique case (phase_eff)
            PH_HEADER: begin
               held_header_in = c;
               held_buttons_in = {c[ps2md_pkg::HDR_LEFT_BIT], c[ps2md_pkg::HDR_MID_BIT],
                                  c[ps2md_pkg::HDR_RIGHT_BIT]} ^ ps2md_pkg::BTN_INVERT;
               sign_x_in = c[ps2md_pkg::HDR_SIGN_X_BIT];
               sign_y_in = c[ps2md_pkg::HDR_SIGN_Y_BIT];
               phase_in = PH_XBYTE;
            end
            PH_XBYTE: begin
               held_xbyte_in = c;
               if (held_header_ff == ps2md_pkg::CONNECT_HEADER &&
                   c == ps2md_pkg::CONNECT_ID) begin
                  phase_in = PH_HOLD;
                  result.connect_seen = 1'b1;
               end else begin
                  if (sign_x_ff) begin
                     held_dx_in = c[ps2md_pkg::BYTE_W-1] ? c : ps2md_pkg::SAT_NEG;
                  end else begin
                     held_dx_in = c[ps2md_pkg::BYTE_W-1] ? ps2md_pkg::SAT_POS : c;
                  end
                  phase_in = PH_YBYTE;
               end
            end
            PH_YBYTE: begin
               if (sign_y_ff) begin
                  dy = (c > ps2md_pkg::BYTE_MID) ? neg_c : ps2md_pkg::SAT_POS;
               end else begin
                  dy = (c < ps2md_pkg::BYTE_MID) ? neg_c : ps2md_pkg::SAT_NEG;
               end
               phase_in = PH_HEADER;
               result.packet_ready = 1'b1;
               result.buttons = held_buttons_ff;
               result.delta_x = held_dx_ff;
               result.delta_y = dy;
               result.raw_first = held_header_ff;
               result.raw_second = held_xbyte_ff;
               result.raw_third = c;
            end
            PH_HOLD: begin
               phase_in = PH_HOLD;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         last_time_ff <= '0;
         held_header_ff <= '0;
         held_xbyte_ff <= '0;
         held_buttons_ff <= '0;
         held_dx_ff <= '0;
         sign_x_ff <= 1'b0;
         sign_y_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         last_time_ff <= last_time_in;
         held_header_ff <= held_header_in;
         held_xbyte_ff <= held_xbyte_in;
         held_buttons_ff <= held_buttons_in;
         held_dx_ff <= held_dx_in;
         sign_x_ff <= sign_x_in;
         sign_y_ff <= sign_y_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ps2_mouse_packet_decoder.sv -----
// PS/2 mouse packet decoder.
// req_chan carries one received byte per item (cmd, data_byte, arrival_time);
// cmd set releases a connect hold and restarts at the header byte.
// rsp_chan returns exactly one item per request item: a finished movement
// packet, the connect flag, or all zeros when the byte completed nothing.
// csr_wr_en/csr_wr_data write the 16-bit gap timeout; write only while idle.
// An accepted request item is captured in the input register, then decoded
// into the response register.
// Throughput: one item per cycle while rsp_chan is not stalled, set by the
// combinational decode between the two registers.
// A stalled response holds in the response register; the input register
// still takes one more item, and req_chan.ready drops only when both are full.
// Reset: parser returns to the header byte, held bytes and last arrival time
// clear to zero, gap timeout returns to 20 ticks, both channels empty;
// req_chan.ready stays low while reset is high.
`default_nettype none

module ps2_mouse_packet_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ps2md_req_if.sink                          req_chan,
   ps2md_rsp_if.source                        rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [ps2md_pkg::GAP_W-1:0]   csr_wr_data
);

   logic [ps2md_pkg::GAP_W-1:0] gap_timeout_ff;
   ps2md_pkg::req_type          req_item;
   ps2md_pkg::req_type          stage_item;
   logic                        stage_valid;
   logic                        advance;
   ps2md_pkg::rsp_type          decoded;
   ps2md_pkg::rsp_type          rsp_data_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_timeout_ff <= ps2md_pkg::GAP_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         gap_timeout_ff <= csr_wr_data;
      end
   end

   assign req_item.cmd = req_chan.cmd;
   assign req_item.data_byte = req_chan.data_byte;
   assign req_item.arrival_time = req_chan.arrival_time;

   ps2md_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   ps2md_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (stage_item),
      .gap_timeout (gap_timeout_ff),
      .result      (decoded)
   );

   assign advance = stage_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= decoded;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.packet_ready = rsp_data_ff.packet_ready;
   assign rsp_chan.connect_seen = rsp_data_ff.connect_seen;
   assign rsp_chan.buttons = rsp_data_ff.buttons;
   assign rsp_chan.delta_x = rsp_data_ff.delta_x;
   assign rsp_chan.delta_y = rsp_data_ff.delta_y;
   assign rsp_chan.raw_first = rsp_data_ff.raw_first;
   assign rsp_chan.raw_second = rsp_data_ff.raw_second;
   assign rsp_chan.raw_third = rsp_data_ff.raw_third;

endmodule

`default_nettype wire
